### src/mpq_pkg.sv
// Shared constants and types of the multi-policy ready-queue scheduler.
package mpq_pkg;

	localparam int ENTRIES = 16;
	localparam int IDXW    = $clog2(ENTRIES);
	localparam int CNTW    = $clog2(ENTRIES + 1);
	localparam int TKTW    = 16;
	localparam int TOTW    = TKTW + IDXW;
	localparam int RNDW    = 31;
	localparam int WAITW   = 32;
	localparam int ATTRW   = 16;
	localparam int TIDW    = 8;

	typedef logic [2:0] policy_t;
	localparam policy_t POL_RR       = 3'd0;
	localparam policy_t POL_HRRN     = 3'd1;
	localparam policy_t POL_LOTTERY  = 3'd2;
	localparam policy_t POL_PRIORITY = 3'd3;
	localparam policy_t POL_MLQ      = 3'd4;

	typedef logic [1:0] cmd_t;
	localparam cmd_t CMD_ENQ    = 2'd0;
	localparam cmd_t CMD_PICK   = 2'd1;
	localparam cmd_t CMD_TICK   = 2'd2;
	localparam cmd_t CMD_UNUSED = 2'd3;

	typedef logic [1:0] list_t;
	localparam list_t LIST_SINGLE = 2'd0;
	localparam list_t LIST_RR     = 2'd1;
	localparam list_t LIST_FCFS   = 2'd2;

endpackage

### src/mpq_chan_if.sv
// Command and result channel interfaces of the scheduler.
interface mpq_cmd_if import mpq_pkg::*; ();
	logic              valid;
	logic              ready;
	cmd_t              cmd;
	logic [TIDW-1:0]   thread_id;
	logic              to_rr_queue;
	logic [ATTRW-1:0]  service_time;
	logic [ATTRW-1:0]  initial_wait;
	logic [TKTW-1:0]   ticket_count;
	logic [ATTRW-1:0]  prio_level;
	logic [RNDW-1:0]   random_value;

	modport source(output valid, cmd, thread_id, to_rr_queue, service_time, initial_wait,
		ticket_count, prio_level, random_value, input ready);
	modport sink(input valid, cmd, thread_id, to_rr_queue, service_time, initial_wait,
		ticket_count, prio_level, random_value, output ready);
endinterface

interface mpq_res_if import mpq_pkg::*; ();
	logic            valid;
	logic            ready;
	logic            found;
	logic [TIDW-1:0] chosen_id;
	logic            dropped;

	modport source(output valid, found, chosen_id, dropped, input ready);
	modport sink(input valid, found, chosen_id, dropped, output ready);
endinterface

### src/mpq_div.sv
// Bit-serial remainder unit: one quotient bit per cycle.
module mpq_div import mpq_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  logic [RNDW-1:0] dividend,
	input  logic [TOTW-1:0] divisor,
	output logic            done,
	output logic [TOTW-1:0] rem
);
	localparam int CW = $clog2(RNDW + 1);

	logic [RNDW-1:0] num_q;
	logic [TOTW-1:0] rem_q;
	logic [CW-1:0]   cnt_q;
	logic            busy_q;
	logic            done_q;
	logic [TOTW:0]   trial;
	logic [TOTW:0]   diff;

	assign trial = {rem_q, num_q[RNDW-1]};
	assign diff  = trial - {1'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_q  <= '0;
			rem_q  <= '0;
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				num_q  <= dividend;
				rem_q  <= '0;
				cnt_q  <= CW'(RNDW);
				busy_q <= 1'b1;
			end else if (busy_q) begin
				// The divisor stays stable for the whole run.
				if (trial >= {1'b0, divisor})
					rem_q <= diff[TOTW-1:0];
				else
					rem_q <= trial[TOTW-1:0];
				num_q <= {num_q[RNDW-2:0], 1'b0};
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done = done_q;
	assign rem  = rem_q;
endmodule

### src/multi_policy_ready_queue_scheduler.sv
// Ready-queue scheduler: one command at a time, entries scanned one per cycle;
// an HRRN comparison also passes through S_HB and S_HC. HRRN picks use the one
// shared multiplier, lottery picks the bit-serial remainder unit. One result
// beat per command. A new command is taken only in the idle state. Reset
// empties the table and sets the policy to MLQ; there is no clearing pass.
module multi_policy_ready_queue_scheduler import mpq_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cfg_we,
	input  logic [2:0] cfg_wdata,
	mpq_cmd_if.sink   cmd_ch,
	mpq_res_if.source res_ch
);
	typedef enum logic [3:0] {
		S_IDLE, S_ENQ, S_TICK, S_SCAN, S_HA, S_HB, S_HC, S_SUM, S_DIV, S_WALK,
		S_DEC, S_REM, S_FIN
	} state_t;

	localparam int KEYW = ATTRW + IDXW;
	localparam int PRODW = WAITW + 1 + ATTRW;

	state_t state_q;
	policy_t pol_q;

	// Captured command.
	logic [TIDW-1:0]  tid_q;
	logic             torr_q;
	logic [ATTRW-1:0] svc_in_q, wait_in_q, prio_in_q;
	logic [TKTW-1:0]  tkt_in_q;
	logic [RNDW-1:0]  rnd_q;

	// Slot table.
	logic             valid_q [ENTRIES];
	logic [TIDW-1:0]  thread_q[ENTRIES];
	list_t            list_q  [ENTRIES];
	logic [ATTRW-1:0] svc_q   [ENTRIES];
	logic [WAITW-1:0] wait_q  [ENTRIES];
	logic [TKTW-1:0]  tkt_q   [ENTRIES];
	logic [ATTRW-1:0] prio_q  [ENTRIES];
	logic [IDXW-1:0]  ord_q   [ENTRIES];
	logic [IDXW-1:0]  rank_q  [ENTRIES];
	logic [CNTW-1:0]  stamp_q;

	// Sequencer registers.
	logic [IDXW-1:0]  idx_q, r_q, best_q;
	logic             found_q, dropped_q;
	logic [KEYW-1:0]  best_key_q;
	logic [WAITW-1:0] best_wait_q;
	logic [ATTRW-1:0] best_svc_q;
	logic [IDXW-1:0]  best_ord_q;
	logic [TIDW-1:0]  best_tid_q;
	logic [PRODW-1:0] lhs_q, rhs_q;
	logic [TOTW-1:0]  tot_q, acc_q, win_q;
	logic             div_start_q;
	logic             ov_q, res_found_q, res_dropped_q;
	logic [TIDW-1:0]  res_id_q;

	// Combinational view of the addressed slot.
	logic [IDXW-1:0]  sidx;
	logic             s_act, is_mlq;
	logic [ATTRW-1:0] s_svc1, b_svc1;
	logic [KEYW-1:0]  s_key;
	logic [ATTRW-1:0] kpri;
	logic [WAITW:0]   add_a;
	logic [ATTRW-1:0] mul_b;
	logic [PRODW-1:0] prod;
	logic [TOTW-1:0]  tot_n, acc_n;
	logic             last, take_walk;
	logic [IDXW-1:0]  free_idx;
	logic             free_ok;
	logic             div_done;
	logic [TOTW-1:0]  div_rem;
	logic             do_enq, do_tick, do_rem;

	assign is_mlq = (pol_q == POL_MLQ);
	assign sidx   = (state_q == S_WALK) ? rank_q[r_q] : idx_q;
	assign s_act  = valid_q[sidx] && (is_mlq ?
		(list_q[sidx] == LIST_RR || list_q[sidx] == LIST_FCFS) : list_q[sidx] == LIST_SINGLE);
	assign s_svc1 = (svc_q[sidx] == '0) ? ATTRW'(1) : svc_q[sidx];
	assign b_svc1 = (best_svc_q == '0) ? ATTRW'(1) : best_svc_q;

	always_comb begin
		if (pol_q == POL_PRIORITY)
			kpri = prio_q[sidx];
		else if (is_mlq)
			kpri = {{(ATTRW-1){1'b0}}, list_q[sidx] == LIST_FCFS};
		else
			kpri = '0;
	end
	assign s_key = {kpri, ord_q[sidx]};

	// Shared adder and multiplier for the HRRN cross products.
	assign add_a = (state_q == S_HA) ?
		({1'b0, wait_q[sidx]} + (WAITW+1)'(s_svc1)) :
		({1'b0, best_wait_q} + (WAITW+1)'(b_svc1));
	assign mul_b = (state_q == S_HA) ? b_svc1 : s_svc1;
	assign prod  = PRODW'(add_a) * PRODW'(mul_b);

	assign tot_n = tot_q + (s_act ? TOTW'(tkt_q[sidx]) : TOTW'(0));
	assign acc_n = acc_q + TOTW'(tkt_q[sidx]);
	assign take_walk = s_act && (tot_q == '0 || acc_n > win_q);
	assign last = (idx_q == IDXW'(ENTRIES - 1));

	always_comb begin
		free_idx = '0;
		free_ok  = 1'b0;
		for (int i = ENTRIES - 1; i >= 0; i--) begin
			if (!valid_q[i]) begin
				free_idx = IDXW'(i);
				free_ok  = 1'b1;
			end
		end
	end

	assign do_enq  = (state_q == S_ENQ) && free_ok;
	assign do_tick = (state_q == S_TICK) && s_act && (wait_q[sidx] != '1);
	assign do_rem  = (state_q == S_REM);

	mpq_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start_q),
		.dividend(rnd_q),
		.divisor (tot_q),
		.done    (div_done),
		.rem     (div_rem)
	);

	// Occupancy and entry count; the count is also the next arrival order.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < ENTRIES; i++)
				valid_q[i] <= 1'b0;
			stamp_q <= '0;
		end else if (do_enq) begin
			valid_q[free_idx] <= 1'b1;
			stamp_q <= stamp_q + 1'b1;
		end else if (do_rem) begin
			valid_q[best_q] <= 1'b0;
			stamp_q <= stamp_q - 1'b1;
		end
	end

	// Slot payload; ranks close the gap left by a removed entry.
	always_ff @(posedge clk) begin
		if (do_enq) begin
			thread_q[free_idx] <= tid_q;
			list_q[free_idx]   <= is_mlq ? (torr_q ? LIST_RR : LIST_FCFS) : LIST_SINGLE;
			svc_q[free_idx]    <= svc_in_q;
			wait_q[free_idx]   <= WAITW'(wait_in_q);
			tkt_q[free_idx]    <= tkt_in_q;
			prio_q[free_idx]   <= prio_in_q;
			ord_q[free_idx]    <= stamp_q[IDXW-1:0];
			rank_q[stamp_q[IDXW-1:0]] <= free_idx;
		end
		if (do_tick)
			wait_q[sidx] <= wait_q[sidx] + 1'b1;
		if (do_rem) begin
			for (int i = 0; i < ENTRIES; i++)
				if (valid_q[i] && ord_q[i] > best_ord_q)
					ord_q[i] <= ord_q[i] - 1'b1;
			for (int r = 0; r < ENTRIES - 1; r++)
				if (IDXW'(r) >= best_ord_q)
					rank_q[r] <= rank_q[r + 1];
		end
	end

	assign cmd_ch.ready = (state_q == S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			pol_q         <= POL_MLQ;
			tid_q         <= '0;
			torr_q        <= 1'b0;
			svc_in_q      <= '0;
			wait_in_q     <= '0;
			tkt_in_q      <= '0;
			prio_in_q     <= '0;
			rnd_q         <= '0;
			idx_q         <= '0;
			r_q           <= '0;
			best_q        <= '0;
			found_q       <= 1'b0;
			dropped_q     <= 1'b0;
			best_key_q    <= '0;
			best_wait_q   <= '0;
			best_svc_q    <= '0;
			best_ord_q    <= '0;
			best_tid_q    <= '0;
			lhs_q         <= '0;
			rhs_q         <= '0;
			tot_q         <= '0;
			acc_q         <= '0;
			win_q         <= '0;
			div_start_q   <= 1'b0;
			ov_q          <= 1'b0;
			res_found_q   <= 1'b0;
			res_dropped_q <= 1'b0;
			res_id_q      <= '0;
		end else begin
			div_start_q <= 1'b0;
			if (cfg_we)
				pol_q <= (cfg_wdata > POL_MLQ) ? POL_RR : cfg_wdata;
			if (ov_q && res_ch.ready && state_q != S_FIN)
				ov_q <= 1'b0;

			unique case (state_q)
				S_IDLE: begin
					if (cmd_ch.valid) begin
						tid_q     <= cmd_ch.thread_id;
						torr_q    <= cmd_ch.to_rr_queue;
						svc_in_q  <= cmd_ch.service_time;
						wait_in_q <= cmd_ch.initial_wait;
						tkt_in_q  <= cmd_ch.ticket_count;
						prio_in_q <= cmd_ch.prio_level;
						rnd_q     <= cmd_ch.random_value;
						idx_q     <= '0;
						r_q       <= '0;
						found_q   <= 1'b0;
						dropped_q <= 1'b0;
						tot_q     <= '0;
						acc_q     <= '0;
						win_q     <= '0;
						unique case (cmd_ch.cmd)
							CMD_ENQ:  state_q <= S_ENQ;
							CMD_TICK: state_q <= S_TICK;
							CMD_PICK: begin
								if (pol_q == POL_HRRN)
									state_q <= S_HA;
								else if (pol_q == POL_LOTTERY)
									state_q <= S_SUM;
								else
									state_q <= S_SCAN;
							end
							default:  state_q <= S_FIN;
						endcase
					end
				end
				S_ENQ: begin
					dropped_q <= !free_ok;
					state_q   <= S_FIN;
				end
				S_TICK: begin
					idx_q <= idx_q + 1'b1;
					if (last)
						state_q <= S_FIN;
				end
				S_SCAN: begin
					if (s_act && (!found_q || s_key < best_key_q)) begin
						found_q    <= 1'b1;
						best_q     <= sidx;
						best_key_q <= s_key;
						best_ord_q <= ord_q[sidx];
						best_tid_q <= thread_q[sidx];
					end
					idx_q <= idx_q + 1'b1;
					if (last)
						state_q <= S_DEC;
				end
				S_HA: begin
					if (s_act && found_q) begin
						lhs_q   <= prod;
						state_q <= S_HB;
					end else begin
						if (s_act) begin
							found_q     <= 1'b1;
							best_q      <= sidx;
							best_wait_q <= wait_q[sidx];
							best_svc_q  <= svc_q[sidx];
							best_ord_q  <= ord_q[sidx];
							best_tid_q  <= thread_q[sidx];
						end
						idx_q <= idx_q + 1'b1;
						if (last)
							state_q <= S_DEC;
					end
				end
				S_HB: begin
					rhs_q   <= prod;
					state_q <= S_HC;
				end
				S_HC: begin
					if (lhs_q > rhs_q || (lhs_q == rhs_q && ord_q[sidx] < best_ord_q)) begin
						best_q      <= sidx;
						best_wait_q <= wait_q[sidx];
						best_svc_q  <= svc_q[sidx];
						best_ord_q  <= ord_q[sidx];
						best_tid_q  <= thread_q[sidx];
					end
					idx_q   <= idx_q + 1'b1;
					state_q <= last ? S_DEC : S_HA;
				end
				S_SUM: begin
					tot_q <= tot_n;
					idx_q <= idx_q + 1'b1;
					if (last) begin
						// With no tickets at all the draw falls back to the earliest entry.
						if (tot_n == '0) begin
							state_q <= S_WALK;
						end else begin
							div_start_q <= 1'b1;
							state_q     <= S_DIV;
						end
					end
				end
				S_DIV: begin
					if (div_done) begin
						win_q   <= div_rem;
						state_q <= S_WALK;
					end
				end
				S_WALK: begin
					if (stamp_q == '0) begin
						state_q <= S_DEC;
					end else begin
						if (s_act)
							acc_q <= acc_n;
						if (take_walk) begin
							found_q    <= 1'b1;
							best_q     <= sidx;
							best_ord_q <= ord_q[sidx];
							best_tid_q <= thread_q[sidx];
							state_q    <= S_DEC;
						end else if (CNTW'(r_q) + 1'b1 == stamp_q) begin
							state_q <= S_DEC;
						end else begin
							r_q <= r_q + 1'b1;
						end
					end
				end
				S_DEC: begin
					state_q <= found_q ? S_REM : S_FIN;
				end
				S_REM: begin
					state_q <= S_FIN;
				end
				S_FIN: begin
					if (!ov_q || res_ch.ready) begin
						ov_q          <= 1'b1;
						res_found_q   <= found_q;
						res_id_q      <= found_q ? best_tid_q : '0;
						res_dropped_q <= dropped_q;
						state_q       <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign res_ch.valid     = ov_q;
	assign res_ch.found     = res_found_q;
	assign res_ch.chosen_id = res_id_q;
	assign res_ch.dropped   = res_dropped_q;
endmodule
